[sv/rlap_pkg.sv]
package rlap_pkg;

	// Frame geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Request codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic MODE_SHARPEN = 1'b0;
	localparam logic MODE_EDGE    = 1'b1;

	localparam logic [7:0] PIXEL_MAX = 8'd255;

	// Window taps are numbered row * 3 + column
	localparam int TAPS       = 9;
	localparam int CENTRE_TAP = 4;

	// Result queue
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

	// Channel 2 is red, 1 green, 0 blue
	typedef logic [2:0][7:0] pix_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_t;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic border;
		logic edge_mode;
	} lane_ctrl_t;

endpackage

[sv/rlap_ram.sv]
module rlap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/rlap_lane.sv]
module rlap_lane (
	input  logic [rlap_pkg::TAPS-1:0][7:0] taps,
	input  logic [7:0]                     centre,
	input  rlap_pkg::lane_ctrl_t           ctrl,
	output logic [7:0]                     result
);

	logic [8:0]         sum_a, sum_b, sum_c, sum_d;
	logic [9:0]         sum_ab, sum_cd;
	logic [10:0]        sum_nb;
	logic [11:0]        weighted;
	logic signed [12:0] diff;

	// Neighbour sum as a small tree, centre tap left out
	assign sum_a  = {1'b0, taps[0]} + {1'b0, taps[1]};
	assign sum_b  = {1'b0, taps[2]} + {1'b0, taps[3]};
	assign sum_c  = {1'b0, taps[5]} + {1'b0, taps[6]};
	assign sum_d  = {1'b0, taps[7]} + {1'b0, taps[8]};
	assign sum_ab = {1'b0, sum_a} + {1'b0, sum_b};
	assign sum_cd = {1'b0, sum_c} + {1'b0, sum_d};
	assign sum_nb = {1'b0, sum_ab} + {1'b0, sum_cd};

	// 8x or 9x centre
	assign weighted = {1'b0, taps[rlap_pkg::CENTRE_TAP], 3'b000}
		+ (ctrl.edge_mode ? 12'd0 : {4'b0000, taps[rlap_pkg::CENTRE_TAP]});

	assign diff = $signed({1'b0, weighted}) - $signed({2'b00, sum_nb});

	always_comb begin
		if (ctrl.border) begin
			result = ctrl.edge_mode ? 8'd0 : centre;
		end else if (diff < 0) begin
			result = 8'd0;
		end else if (diff > $signed({5'd0, rlap_pkg::PIXEL_MAX})) begin
			result = rlap_pkg::PIXEL_MAX;
		end else begin
			result = diff[7:0];
		end
	end

endmodule

[sv/rlap_ofifo.sv]
module rlap_ofifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  rlap_pkg::out_item_t                 push_data,
	input  logic                                pop,
	output logic                                not_empty,
	output rlap_pkg::out_item_t                 head,
	output logic [rlap_pkg::OFIFO_CNT_W-1:0]    count
);

	rlap_pkg::out_item_t                 mem_q [rlap_pkg::OFIFO_DEPTH];
	logic [rlap_pkg::OFIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [rlap_pkg::OFIFO_CNT_W-1:0]    cnt_q;

	function automatic logic [rlap_pkg::OFIFO_PTR_W-1:0] ptr_next(
		input logic [rlap_pkg::OFIFO_PTR_W-1:0] p
	);
		ptr_next = (p == rlap_pkg::OFIFO_PTR_W'(rlap_pkg::OFIFO_DEPTH - 1))
			? '0 : p + rlap_pkg::OFIFO_PTR_W'(1);
	endfunction

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + rlap_pkg::OFIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - rlap_pkg::OFIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/rgb_laplacian_3x3_filter_core.sv]
// RGB 3x3 Laplacian sharpen / edge filter, streaming.
//
// Input channel pix_valid/pix_ready/pix_data takes one request per clock: a
// pixel in raster order, or a flush request that drains one pending result
// once the whole frame is in. Output channel res_valid/res_ready/res_data
// gives one filtered pixel per pixel in, trailing the stream by one row plus
// one pixel; frame_end marks the last pixel of a frame. The last row plus
// one pixel of a frame come out only for flush requests.
//
// Throughput is one request per cycle while pix_ready is high; one line
// store RAM write and one registered read per cycle, three color lanes
// side by side. Each result is registered in stage 1, then lands in a
// four-deep queue; pix_ready drops only when the queue plus the request in
// flight could overfill, so a stalled receiver throttles the input without
// any combinational path between them.
//
// Reset clears the frame counters and the queue and loads mode sharpen,
// width 640, height 480. Line store contents stay undefined; no output ever
// depends on an entry not yet written in the current frame. Writing width or
// height restarts the frame; write registers only while the block is idle.
module rgb_laplacian_3x3_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  rlap_pkg::in_item_t                  pix_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output rlap_pkg::out_item_t                 res_data,
	input  logic                                wr_en,
	input  logic [rlap_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [rlap_pkg::CFG_DATA_W-1:0]     wr_data
);

	localparam int COL_W    = rlap_pkg::COL_W;
	localparam int WIDTH_W  = rlap_pkg::WIDTH_W;
	localparam int HEIGHT_W = rlap_pkg::HEIGHT_W;

	// Configuration, held as effective (clamped) values
	logic                mode_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [WIDTH_W-1:0]  wr_width;
	logic [WIDTH_W-1:0]  eff_width;
	logic [HEIGHT_W-1:0] eff_height;

	// Frame position of the next pixel in and the next result out
	logic [COL_W-1:0]    in_col_q, out_col_q;
	logic [HEIGHT_W-1:0] in_row_q, out_row_q;

	// Request decode
	logic             accept, is_flush, frame_in_done;
	logic             do_pixel, do_flush, pix_emit, emit_s0;
	logic             in_col_last, out_col_last, out_row_last;
	logic             border_s0, last_s0;
	logic [COL_W-1:0] rd_addr;

	// Stage 1: line store data back, window shift, lane filters
	logic              pixel_s1, emit_s1, border_s1, last_s1, sel_mid_s1;
	rlap_pkg::pix_t    pix_s1;
	logic [COL_W-1:0]  addr_s1;
	logic              fwd_s1;
	rlap_pkg::line_t   fwd_data_s1;
	logic [$bits(rlap_pkg::line_t)-1:0] ram_rdata;
	rlap_pkg::line_t   line_rd, line_wr;

	rlap_pkg::pix_t [rlap_pkg::TAPS-1:0] win_q, win_d;
	rlap_pkg::pix_t    centre;
	rlap_pkg::lane_ctrl_t lane_ctrl;
	logic [2:0][7:0]   lane_res;

	rlap_pkg::out_item_t                 res_item;
	logic [rlap_pkg::OFIFO_CNT_W-1:0]    fifo_cnt;

	// ---------------------------------------------------------------
	// Configuration decode
	// ---------------------------------------------------------------
	assign wr_width = wr_data[WIDTH_W-1:0];

	always_comb begin
		if (wr_width == '0) begin
			eff_width = WIDTH_W'(1);
		end else if (wr_width > WIDTH_W'(rlap_pkg::MAX_WIDTH)) begin
			eff_width = WIDTH_W'(rlap_pkg::MAX_WIDTH);
		end else begin
			eff_width = wr_width;
		end
		eff_height = (wr_data[HEIGHT_W-1:0] == '0) ? HEIGHT_W'(1) : wr_data[HEIGHT_W-1:0];
	end

	// ---------------------------------------------------------------
	// Stage 0: accept, classify, step the frame counters
	// ---------------------------------------------------------------
	// Reserve a queue slot for every result that is still in flight.
	assign pix_ready = (fifo_cnt + rlap_pkg::OFIFO_CNT_W'(emit_s1))
		< rlap_pkg::OFIFO_CNT_W'(rlap_pkg::OFIFO_DEPTH);

	assign accept        = pix_valid && pix_ready;
	assign is_flush      = (pix_data.op == rlap_pkg::OP_FLUSH);
	assign frame_in_done = (in_row_q >= height_q);

	// Drop pixels past the frame end and flushes that come too early.
	assign do_pixel = accept && !is_flush && !frame_in_done;
	assign do_flush = accept && is_flush && frame_in_done;

	// The first row plus one pixel only fill the window.
	assign pix_emit = !((in_row_q == '0) ||
		((in_row_q == HEIGHT_W'(1)) && (in_col_q == '0)));
	assign emit_s0  = do_flush || (do_pixel && pix_emit);

	assign in_col_last  = ({1'b0, in_col_q} == width_q - WIDTH_W'(1));
	assign out_col_last = ({1'b0, out_col_q} == width_q - WIDTH_W'(1));
	assign out_row_last = (out_row_q == height_q - HEIGHT_W'(1));
	assign border_s0    = (out_row_q == '0) || out_row_last || (out_col_q == '0) || out_col_last;
	assign last_s0      = out_row_last && out_col_last;

	// Flush reads the column of the result it drains.
	assign rd_addr = is_flush ? out_col_q : in_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rlap_pkg::MODE_SHARPEN;
			width_q   <= WIDTH_W'(640);
			height_q  <= HEIGHT_W'(480);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				rlap_pkg::REG_MODE: begin
					mode_q <= wr_data[0];
				end
				rlap_pkg::REG_WIDTH: begin
					width_q   <= eff_width;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				rlap_pkg::REG_HEIGHT: begin
					height_q  <= eff_height;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				default: begin
					// unknown register: drop the write
				end
			endcase
		end else begin
			if (do_pixel) begin
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HEIGHT_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (emit_s0) begin
				// Last result of the frame restarts everything, the input
				// position included.
				if (last_s0) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HEIGHT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			pixel_s1 <= do_pixel;
			emit_s1  <= emit_s0;
			// Same column written by stage 1 this cycle: take its data.
			fwd_s1   <= pixel_s1 && (addr_s1 == rd_addr);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		border_s1   <= border_s0;
		last_s1     <= last_s0;
		sel_mid_s1  <= out_row_last;
		pix_s1      <= {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
		addr_s1     <= rd_addr;
		fwd_data_s1 <= line_wr;
	end

	// ---------------------------------------------------------------
	// Line store: {upper, middle} per column
	// ---------------------------------------------------------------
	rlap_ram #(
		.WIDTH ($bits(rlap_pkg::line_t)),
		.DEPTH (rlap_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (pixel_s1),
		.waddr (addr_s1),
		.wdata (line_wr),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign line_rd = fwd_s1 ? fwd_data_s1 : rlap_pkg::line_t'(ram_rdata);

	// Middle row moves up, the new pixel becomes the middle row.
	always_comb begin
		line_wr.upper  = line_rd.middle;
		line_wr.middle = pix_s1;
	end

	// ---------------------------------------------------------------
	// Window: advance one column per pixel, hold on flush
	// ---------------------------------------------------------------
	always_comb begin
		win_d = win_q;
		if (pixel_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_d[r*3]     = win_q[r*3 + 1];
				win_d[r*3 + 1] = win_q[r*3 + 2];
			end
			win_d[2] = line_rd.upper;
			win_d[5] = line_rd.middle;
			win_d[8] = pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	// Flushed results are all on the border; their centre comes straight
	// from the line store, the middle copy when it sits in the last row.
	always_comb begin
		if (pixel_s1) begin
			centre = win_d[rlap_pkg::CENTRE_TAP];
		end else if (sel_mid_s1) begin
			centre = line_rd.middle;
		end else begin
			centre = line_rd.upper;
		end
	end

	assign lane_ctrl.border    = border_s1;
	assign lane_ctrl.edge_mode = (mode_q == rlap_pkg::MODE_EDGE);

	// ---------------------------------------------------------------
	// One filter lane per color channel
	// ---------------------------------------------------------------
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [rlap_pkg::TAPS-1:0][7:0] taps;

		always_comb begin
			for (int k = 0; k < rlap_pkg::TAPS; k++) begin
				taps[k] = win_d[k][ch];
			end
		end

		rlap_lane u_lane (
			.taps   (taps),
			.centre (centre[ch]),
			.ctrl   (lane_ctrl),
			.result (lane_res[ch])
		);
	end

	// ---------------------------------------------------------------
	// Merge lanes into a result and queue it
	// ---------------------------------------------------------------
	always_comb begin
		res_item.red_out   = lane_res[2];
		res_item.green_out = lane_res[1];
		res_item.blue_out  = lane_res[0];
		res_item.frame_end = last_s1;
	end

	rlap_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s1),
		.push_data (res_item),
		.pop       (res_valid && res_ready),
		.not_empty (res_valid),
		.head      (res_data),
		.count     (fifo_cnt)
	);

endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Index past the end of the register list; the block must ignore it
	localparam logic [rlap_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int SHARPEN_CENTRE = 9;
	localparam int EDGE_CENTRE    = 8;

	localparam int IDLE_PCT      = 18;
	localparam int RANDOM_ITEMS  = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 5000;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            pix_valid = 1'b0;
	logic                            pix_ready;
	rlap_pkg::in_item_t              pix_data  = '0;
	logic                            res_valid;
	logic                            res_ready = 1'b0;
	rlap_pkg::out_item_t             res_data;
	logic                            wr_en     = 1'b0;
	logic [rlap_pkg::CFG_IDX_W-1:0]  wr_index  = '0;
	logic [rlap_pkg::CFG_DATA_W-1:0] wr_data   = '0;

	rgb_laplacian_3x3_filter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to go out, and filtered pixels the block still owes us
	rlap_pkg::in_item_t  send_queue [$];
	rlap_pkg::out_item_t filtered_due [$];

	// Both sides stop idling while calm is set
	bit calm = 1'b0;
	int mismatches = 0;
	int random_count = 0;
	int stall_cycles = 0;

	// First directed frame, raster order
	logic [23:0] first_frame [9] = '{24'h000000, 24'hFF0000, 24'h00FF00,
		24'h0000FF, 24'hFFFFFF, 24'h804020, 24'hFFFFFF, 24'h010203, 24'h000000};

	// Shadow of the filter: line stores, 3x3 window, counters and registers.
	// Pixels are packed red in [23:16], green in [15:8], blue in [7:0].
	bit [23:0]   upper_row  [rlap_pkg::MAX_WIDTH];
	bit [23:0]   middle_row [rlap_pkg::MAX_WIDTH];
	bit [23:0]   window     [3][3];
	int unsigned in_col    = 0;
	int unsigned in_row    = 0;
	int unsigned out_count = 0;
	bit                          cur_mode   = rlap_pkg::MODE_SHARPEN;
	bit [rlap_pkg::WIDTH_W-1:0]  cur_width  = 11'd640;
	bit [rlap_pkg::HEIGHT_W-1:0] cur_height = 16'd480;

	// Clamp the programmed size into the range the block supports
	function automatic int unsigned frame_width();
		if (cur_width == 0)
			return 1;
		if (cur_width > rlap_pkg::MAX_WIDTH)
			return rlap_pkg::MAX_WIDTH;
		return cur_width;
	endfunction

	function automatic int unsigned frame_height();
		return (cur_height == 0) ? 1 : cur_height;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_count = 0;
	endfunction

	// One color lane of the Laplacian at the current window position
	function automatic logic [7:0] lap_channel(int sh, bit border, bit [23:0] centre);
		int acc;
		if (border)
			return (cur_mode == rlap_pkg::MODE_EDGE) ? 8'd0 : centre[sh +: 8];
		acc = ((cur_mode == rlap_pkg::MODE_EDGE) ? EDGE_CENTRE : SHARPEN_CENTRE) *
			int'(window[1][1][sh +: 8]);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (i != 1 || j != 1)
					acc -= int'(window[i][j][sh +: 8]);
		if (acc < 0)
			acc = 0;
		if (acc > int'(rlap_pkg::PIXEL_MAX))
			acc = int'(rlap_pkg::PIXEL_MAX);
		return acc[7:0];
	endfunction

	// Produce the next output pixel in raster order around the given centre
	task automatic emit_pixel(bit [23:0] centre);
		int unsigned w, h, r, c;
		bit border;
		rlap_pkg::out_item_t px;
		w = frame_width();
		h = frame_height();
		r = out_count / w;
		c = out_count % w;
		border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		px.red_out   = lap_channel(16, border, centre);
		px.green_out = lap_channel(8, border, centre);
		px.blue_out  = lap_channel(0, border, centre);
		out_count++;
		px.frame_end = (out_count == w * h);
		if (px.frame_end)
			restart_frame();
		filtered_due.push_back(px);
	endtask

	// Advance the shadow filter by one accepted request
	task automatic filter_request(rlap_pkg::in_item_t req);
		int unsigned w, h, ic, idx, r, c;
		bit [23:0] pix, prior;
		w = frame_width();
		h = frame_height();
		if (req.op == rlap_pkg::OP_FLUSH) begin
			// Drain only once the whole frame is in and something is pending
			if (in_row < h || out_count >= w * h)
				return;
			r = out_count / w;
			c = out_count % w;
			emit_pixel((r == h - 1) ? middle_row[c] : upper_row[c]);
			return;
		end
		// Drop pixels that arrive after the frame was taken in
		if (in_row >= h)
			return;
		pix = {req.red_in, req.green_in, req.blue_in};
		ic = in_col % w;
		idx = in_row * w + ic;
		prior = window[1][2];
		for (int i = 0; i < 3; i++) begin
			window[i][0] = window[i][1];
			window[i][1] = window[i][2];
		end
		window[0][2] = upper_row[ic];
		window[1][2] = middle_row[ic];
		window[2][2] = pix;
		upper_row[ic] = middle_row[ic];
		middle_row[ic] = pix;
		in_col = ic + 1;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (idx < w + 1 || out_count >= w * h)
			return;
		// At the start of a row the centre was the previous row's last pixel
		emit_pixel((ic == 0) ? prior : window[1][1]);
	endtask

	function automatic rlap_pkg::in_item_t pixel_of(logic [23:0] rgb);
		rlap_pkg::in_item_t item;
		item.op = rlap_pkg::OP_PIXEL;
		{item.red_in, item.green_in, item.blue_in} = rgb;
		return item;
	endfunction

	// Flush requests carry random color bits that the block must ignore
	function automatic rlap_pkg::in_item_t flush_item();
		rlap_pkg::in_item_t item;
		item.op = rlap_pkg::OP_FLUSH;
		{item.red_in, item.green_in, item.blue_in} = 24'($urandom);
		return item;
	endfunction

	// Mix clamp-heavy extremes, full-range noise and mid-gray values
	function automatic logic [7:0] channel_value();
		int pick;
		pick = $urandom_range(9);
		if (pick < 3)
			return ($urandom_range(1) == 1) ? rlap_pkg::PIXEL_MAX : 8'd0;
		if (pick < 6)
			return 8'($urandom);
		return 8'($urandom_range(150, 100));
	endfunction

	function automatic rlap_pkg::in_item_t random_pixel();
		return pixel_of({channel_value(), channel_value(), channel_value()});
	endfunction

	// Issue one register write; the shadow takes the value before the block does
	task automatic write_reg(logic [rlap_pkg::CFG_IDX_W-1:0] idx,
			logic [rlap_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			rlap_pkg::REG_MODE: begin
				cur_mode = data[0];
			end
			rlap_pkg::REG_WIDTH: begin
				cur_width = data[rlap_pkg::WIDTH_W-1:0];
				restart_frame();
			end
			rlap_pkg::REG_HEIGHT: begin
				cur_height = data[rlap_pkg::HEIGHT_W-1:0];
				restart_frame();
			end
			default: begin
			end
		endcase
	endtask

	task automatic set_registers(logic [rlap_pkg::CFG_DATA_W-1:0] mode_word,
			logic [rlap_pkg::CFG_DATA_W-1:0] width_word,
			logic [rlap_pkg::CFG_DATA_W-1:0] height_word,
			bit sizes, bit spare);
		write_reg(rlap_pkg::REG_MODE, mode_word);
		if (sizes) begin
			write_reg(rlap_pkg::REG_WIDTH, width_word);
			write_reg(rlap_pkg::REG_HEIGHT, height_word);
		end
		if (spare)
			write_reg(REG_SPARE, 16'($urandom));
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Queue npix pixels of the current frame; with drain, flush out the tail.
	// Noisy frames add early flushes, late pixels and flushes past the end.
	task automatic queue_frame(int unsigned npix, bit drain, bit noisy);
		int unsigned w, total, tail;
		w = frame_width();
		total = w * frame_height();
		for (int unsigned k = 0; k < npix; k++) begin
			if (noisy && $urandom_range(99) < 4)
				send_queue.push_back(flush_item());
			send_queue.push_back(random_pixel());
		end
		random_count += npix;
		if (drain) begin
			if (noisy)
				repeat ($urandom_range(2)) send_queue.push_back(random_pixel());
			tail = (total < w + 1) ? total : w + 1;
			repeat (tail) send_queue.push_back(flush_item());
			random_count += tail;
			if (noisy)
				repeat ($urandom_range(2)) send_queue.push_back(flush_item());
		end
	endtask

	// Wait until every request is out and every result is back, then let
	// any request that gives no result clear the pipeline
	task automatic wait_idle();
		while (send_queue.size() != 0 || pix_valid || filtered_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: hold the request until accepted, else load the next one or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ready)
				filter_request(pix_data);
			if (!pix_valid || pix_ready) begin
				if (send_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					pix_valid <= 1'b1;
					pix_data <= send_queue.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest filtered pixel due
	always @(posedge clk) begin
		rlap_pkg::out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (filtered_due.size() == 0) begin
				$error("result %h with no pixel due", res_data);
				mismatches++;
			end else begin
				want = filtered_due.pop_front();
				if (res_data.red_out !== want.red_out) begin
					$error("red_out: expected %0d, got %0d", want.red_out, res_data.red_out);
					mismatches++;
				end
				if (res_data.green_out !== want.green_out) begin
					$error("green_out: expected %0d, got %0d", want.green_out,
						res_data.green_out);
					mismatches++;
				end
				if (res_data.blue_out !== want.blue_out) begin
					$error("blue_out: expected %0d, got %0d", want.blue_out, res_data.blue_out);
					mismatches++;
				end
				if (res_data.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end,
						res_data.frame_end);
					mismatches++;
				end
			end
		end
		res_ready <= calm || $urandom_range(99) >= IDLE_PCT;
	end

	// Watchdog: end the run if nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int phase, pick;
		int unsigned w, total, npix;
		bit frame_open, tall, partial, sizes;
		logic [rlap_pkg::CFG_DATA_W-1:0] width_word, height_word;

		phase = 0;
		frame_open = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Sharpen a 3x3 frame: early flush, bright centre that clamps high,
		// a late pixel the block must drop, the drain, and a flush past the end
		set_registers({15'd0, rlap_pkg::MODE_SHARPEN}, 16'd3, 16'd3, 1'b1, 1'b0);
		send_queue.push_back(flush_item());
		foreach (first_frame[k])
			send_queue.push_back(pixel_of(first_frame[k]));
		send_queue.push_back(pixel_of(24'hFFFFFF));
		repeat (4) send_queue.push_back(flush_item());
		send_queue.push_back(flush_item());
		wait_idle();

		// Edge mode: dark centre among white neighbors clamps low; borders go
		// to zero. Also poke the register index past the list.
		set_registers({15'd0, rlap_pkg::MODE_EDGE}, 16'd3, 16'd3, 1'b1, 1'b1);
		for (int k = 0; k < 9; k++)
			send_queue.push_back(pixel_of((k == rlap_pkg::CENTRE_TAP) ?
				24'h000000 : 24'hFFFFFF));
		repeat (4) send_queue.push_back(flush_item());
		wait_idle();

		// Random frames with random geometry until enough requests have gone
		while (random_count < RANDOM_ITEMS) begin
			phase++;
			calm = (phase % 6 == 4);
			pick = $urandom_range(99);
			if (pick < 6)
				width_word = {5'($urandom), 11'd0};
			else if (pick < 12)
				width_word = 16'd1;
			else if (pick < 18)
				width_word = 16'($urandom_range(40, 9));
			else
				width_word = 16'($urandom_range(8, 2));
			pick = $urandom_range(99);
			tall = (pick >= 6 && pick < 10);
			if (pick < 6)
				height_word = 16'd0;
			else if (tall)
				height_word = 16'hFFFF;
			else
				height_word = 16'($urandom_range(6, 1));
			// After a clean frame that is not tall, sometimes change only the mode
			sizes = frame_open || tall || $urandom_range(99) >= 20;
			set_registers({15'($urandom), 1'($urandom)}, width_word, height_word,
				sizes, $urandom_range(99) < 10);
			w = frame_width();
			total = w * frame_height();
			partial = tall || $urandom_range(99) < 8;
			if (tall)
				npix = w * $urandom_range(4, 1) + $urandom_range(w - 1);
			else if (partial)
				npix = $urandom_range(total - 1);
			else
				npix = total;
			queue_frame(npix, !partial, $urandom_range(99) < 30);
			frame_open = partial;
			wait_idle();
		end

		calm = 1'b0;
		wait_idle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
